FILE: rtl/hmc_pkg.sv
// ----------------------------------------------------------------------------
// hmc_pkg: shared types and codes of the hashed multiset counter
// Operation and status codes, and the command and status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hmc_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_PURGE  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  localparam int          OUT_W   = 22;
  localparam logic [21:0] OUT_MAX = 22'h3FFFFF;

  // Cycles of the bucket hash: byte fold, reciprocal multiply, remainder
  localparam int DIV_STEPS = 3;

  typedef struct packed {
    logic accept;    // latch the input transfer, start the remainder
    logic div_step;  // advance the remainder unit
    logic use_ptr;   // address the store by the sweep pointer
    logic mem_rd;    // load the row register from the store
    logic mem_wr;    // write the row register back
    logic clr;       // write an empty row instead
    logic exec;      // apply the operation to the row register
    logic ptr_inc;   // advance the sweep pointer
    logic way_clr;   // restart the way counter
    logic way_step;  // purge one way and advance
  } hmc_cmd_t;

  typedef struct packed {
    logic div_last;
    logic ptr_last;
    logic way_last;
  } hmc_stat_t;

endpackage

`default_nettype wire

FILE: rtl/hmc_ctrl.sv
// ----------------------------------------------------------------------------
// hmc_ctrl: sequencer of the hashed multiset counter
// Steps through the store clear after reset, the bucket read-modify-write
// of add, remove and query, and the row-by-row purge sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module hmc_ctrl
  import hmc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire logic [1:0] op,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire hmc_stat_t stat,
  output hmc_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_READ, S_EXEC, S_WRITE, S_RESULT,
    S_P_READ, S_P_WAY, S_P_WRITE
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  // Decode commands from the state
  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.use_ptr = 1'b1;
        cmd.mem_wr  = 1'b1;
        cmd.clr     = 1'b1;
        cmd.ptr_inc = 1'b1;
      end
      S_IDLE:   cmd.accept   = in_valid;
      S_DIV:    cmd.div_step = 1'b1;
      S_READ:   cmd.mem_rd   = 1'b1;
      S_EXEC:   cmd.exec     = 1'b1;
      S_WRITE:  cmd.mem_wr   = 1'b1;
      S_P_READ: begin
        cmd.use_ptr = 1'b1;
        cmd.mem_rd  = 1'b1;
        cmd.way_clr = 1'b1;
      end
      S_P_WAY:  cmd.way_step = 1'b1;
      S_P_WRITE: begin
        cmd.use_ptr = 1'b1;
        cmd.mem_wr  = 1'b1;
        cmd.ptr_inc = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  // Hold state and the result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR:  if (stat.ptr_last) state <= S_IDLE;
        S_IDLE: begin
          if (in_valid) state <= (op == OP_PURGE) ? S_P_READ : S_DIV;
        end
        S_DIV:    if (stat.div_last) state <= S_READ;
        S_READ:   state <= S_EXEC;
        S_EXEC:   state <= S_WRITE;
        S_WRITE: begin
          state     <= S_RESULT;
          out_valid <= 1'b1;
        end
        S_RESULT: begin
          if (!out_stall) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
          end
        end
        S_P_READ: state <= S_P_WAY;
        S_P_WAY:  if (stat.way_last) state <= S_P_WRITE;
        S_P_WRITE: begin
          if (stat.ptr_last) begin
            state     <= S_RESULT;
            out_valid <= 1'b1;
          end else begin
            state <= S_P_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hmc_dp.sv
// ----------------------------------------------------------------------------
// hmc_dp: datapath of the hashed multiset counter
// Bucket remainder unit, bucket store with its row register, per-row
// update logic, purge accumulator, occupancy total and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hmc_dp
  import hmc_pkg::*;
#(
  parameter int BUCKETS    = 16,
  parameter int WAYS       = 4,
  parameter int COUNT_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hmc_cmd_t          cmd,
  output hmc_stat_t              stat,
  input  wire logic [1:0]        op,
  input  wire logic signed [31:0] key,
  output logic [1:0]             status,
  output logic [OUT_W-1:0]       count,
  output logic [OUT_W-1:0]       total_size,
  output logic                   is_empty
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int EW    = 1 + 32 + COUNT_BITS;
  localparam int ROW_W = WAYS * EW;
  localparam int TOT_W = $clog2(BUCKETS * WAYS) + COUNT_BITS;
  localparam int MW    = (TOT_W > OUT_W) ? TOT_W : OUT_W;
  localparam int SW    = $clog2(DIV_STEPS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Byte fold of the magnitude: each byte weighted by 256^i mod BUCKETS
  localparam int FW = BW + 10;
  localparam logic [FW-1:0] RES1 = FW'(256 % BUCKETS);
  localparam logic [FW-1:0] RES2 = FW'(65536 % BUCKETS);
  localparam logic [FW-1:0] RES3 = FW'(16777216 % BUCKETS);
  localparam logic [FW-1:0] BUCKET_C = FW'(BUCKETS);
  // Reciprocal of BUCKETS, exact quotient for any folded value below 2^FW
  localparam int SH = FW + BW;
  localparam int PW = 2 * FW + 1;
  localparam int QW = PW - SH;
  localparam logic [FW:0] RCP =
    (FW+1)'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  logic [1:0]        op_q;
  logic [31:0]       key_q;
  logic [31:0]       mag;
  logic [FW-1:0]     fold;
  logic [FW-1:0]     fold_next;
  logic [PW-1:0]     prod;
  logic [QW-1:0]     quo;
  logic [FW-1:0]     rem_full;
  logic [BW-1:0]     rem;
  logic [SW-1:0]     step;
  logic [BW-1:0]     ptr;
  logic [WW-1:0]     way;
  logic [ROW_W-1:0]  mem [BUCKETS];
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_upd;
  logic [BW-1:0]     addr;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  total_upd;
  logic [TOT_W-1:0]  res_cnt;
  logic [TOT_W-1:0]  res_cnt_upd;
  logic [1:0]        res_status;
  logic [1:0]        status_upd;

  logic                  r_valid [WAYS];
  logic [31:0]           r_key   [WAYS];
  logic [COUNT_BITS-1:0] r_cnt   [WAYS];

  assign stat.div_last = (step == SW'(DIV_STEPS - 1));
  assign stat.ptr_last = (ptr == BW'(BUCKETS - 1));
  assign stat.way_last = (way == WW'(WAYS - 1));

  assign addr = cmd.use_ptr ? ptr : rem;

  // Unpack the row register
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      r_valid[w] = row[w*EW + EW - 1];
      r_key[w]   = row[w*EW + COUNT_BITS +: 32];
      r_cnt[w]   = row[w*EW +: COUNT_BITS];
    end
  end

  // Bucket hash: fold the bytes, multiply by the reciprocal, take the remainder
  always_comb begin
    fold_next = FW'(mag[7:0]) + FW'(mag[15:8]) * RES1 + FW'(mag[23:16]) * RES2
              + FW'(mag[31:24]) * RES3;
    prod      = PW'(fold) * PW'(RCP);
    rem_full  = fold - FW'(quo) * BUCKET_C;
  end

  // Apply add, remove or query to the bucket row
  always_comb begin
    logic hit;
    logic fre;
    logic [WW-1:0] hit_w;
    logic [WW-1:0] free_w;
    hit    = 1'b0;
    fre    = 1'b0;
    hit_w  = '0;
    free_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (r_valid[w] && r_key[w] == key_q) begin
        hit   = 1'b1;
        hit_w = WW'(w);
      end
      if (!r_valid[w]) begin
        fre    = 1'b1;
        free_w = WW'(w);
      end
    end
    row_upd     = row;
    total_upd   = total;
    res_cnt_upd = '0;
    status_upd  = ST_OK;
    case (op_q)
      OP_ADD: begin
        if (hit) begin
          if (r_cnt[hit_w] == COUNT_MAX) begin
            status_upd  = ST_SATURATED;
            res_cnt_upd = TOT_W'(COUNT_MAX);
          end else begin
            row_upd[hit_w*EW +: COUNT_BITS] = r_cnt[hit_w] + 1'b1;
            total_upd   = total + 1'b1;
            res_cnt_upd = TOT_W'(r_cnt[hit_w]) + 1'b1;
          end
        end else if (fre) begin
          row_upd[free_w*EW +: EW] = {1'b1, key_q, COUNT_BITS'(1)};
          total_upd   = total + 1'b1;
          res_cnt_upd = TOT_W'(1);
        end else begin
          status_upd = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          row_upd[hit_w*EW +: COUNT_BITS] = r_cnt[hit_w] - 1'b1;
          if (r_cnt[hit_w] == COUNT_BITS'(1)) row_upd[hit_w*EW + EW - 1] = 1'b0;
          total_upd   = total - 1'b1;
          res_cnt_upd = TOT_W'(r_cnt[hit_w]) - 1'b1;
        end else begin
          status_upd = ST_NOT_FOUND;
        end
      end
      default: begin
        if (hit) res_cnt_upd = TOT_W'(r_cnt[hit_w]);
        else status_upd = ST_NOT_FOUND;
      end
    endcase
  end

  // Store: one row per bucket, registered read into the row register
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[addr] <= cmd.clr ? '0 : row;
    if (cmd.mem_rd) begin
      row <= mem[addr];
    end else if (cmd.exec) begin
      row <= row_upd;
    end else if (cmd.way_step) begin
      if (r_valid[way] && r_cnt[way] > COUNT_BITS'(1)) row[way*EW + EW - 1] <= 1'b0;
    end
  end

  // Latch the transfer and run the remainder
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= op;
      key_q <= key;
      mag   <= key[31] ? (32'd0 - key) : key;
    end else if (cmd.div_step) begin
      fold <= fold_next;
      quo  <= prod[PW-1:SH];
      rem  <= rem_full[BW-1:0];
    end
  end

  // Control counters, total and result
  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      ptr   <= '0;
      way   <= '0;
      total <= '0;
    end else begin
      if (cmd.accept) step <= '0;
      else if (cmd.div_step) step <= step + 1'b1;
      if (cmd.ptr_inc) ptr <= stat.ptr_last ? '0 : ptr + 1'b1;
      if (cmd.way_clr) way <= '0;
      else if (cmd.way_step && !stat.way_last) way <= way + 1'b1;
      if (cmd.exec) total <= total_upd;
      else if (cmd.way_step && r_valid[way] && r_cnt[way] > COUNT_BITS'(1))
        total <= total - TOT_W'(r_cnt[way]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status <= ST_OK;
      res_cnt    <= '0;
    end else if (cmd.exec) begin
      res_status <= status_upd;
      res_cnt    <= res_cnt_upd;
    end else if (cmd.way_step && r_valid[way] && r_cnt[way] > COUNT_BITS'(1)) begin
      res_cnt <= res_cnt + TOT_W'(r_cnt[way]);
    end
  end

  // Saturate the reported figures
  always_comb begin
    logic [MW-1:0] c;
    logic [MW-1:0] t;
    c = MW'(res_cnt);
    t = MW'(total);
    status     = res_status;
    count      = (c > MW'(OUT_MAX)) ? OUT_MAX : c[OUT_W-1:0];
    total_size = (t > MW'(OUT_MAX)) ? OUT_MAX : t[OUT_W-1:0];
    is_empty   = (total == '0);
  end

endmodule

`default_nettype wire

FILE: rtl/hash_multiset_counter.sv
// ----------------------------------------------------------------------------
// hash_multiset_counter: hashed bag of signed keys with occurrence counts
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries op and key; a transfer happens at
//   a clock edge with in_valid high and in_stall low. Output channel
//   out_valid/out_stall carries status, count, total_size and is_empty, one
//   result per input transfer.
//   Add, remove and query run the bucket hash (byte fold, reciprocal
//   multiply, remainder), then read, update and write back that bucket's
//   row in the store, and then raise out_valid.
//   Purge sweeps the store row by row, reading each row, purging its ways
//   one by one and writing the row back; out_valid rises after the last row.
//   One item is in flight at a time; in_stall stays high until the result
//   has been taken, and a stalled result holds its value.
//   After reset the store is cleared one row per cycle, every row in turn,
//   with in_stall high throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_multiset_counter
  import hmc_pkg::*;
#(
  parameter int BUCKETS    = 16,
  parameter int WAYS       = 4,
  parameter int COUNT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         op,
  input  wire logic signed [31:0] key,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic [21:0]             count,
  output logic [21:0]             total_size,
  output logic                    is_empty
);

  hmc_cmd_t  cmd;
  hmc_stat_t stat;

  hmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  hmc_dp #(
    .BUCKETS    (BUCKETS),
    .WAYS       (WAYS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .op         (op),
    .key        (key),
    .status     (status),
    .count      (count),
    .total_size (total_size),
    .is_empty   (is_empty)
  );

endmodule

`default_nettype wire
